// ===== rtl/core/nalsp_pkg.sv =====
// shared types, constants and helpers of the annex b nal unit splitter
// no dependencies
package nalsp_pkg;

    localparam int CFG_W           = 20;
    localparam int LENGTH_BITS_DEF = 20;
    localparam int WIN_DEPTH       = 4;
    localparam int SEG_N           = 5;
    localparam int MAX_RES         = 6;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [CFG_W-1:0] MAX_NAL_RESET = 20'd65536;
    localparam logic             REG_MAX_NAL_LENGTH = 1'b0;

    localparam logic [7:0] ZERO_BYTE     = 8'h00;
    localparam logic [7:0] CODE_BYTE     = 8'h01;
    localparam logic [7:0] HDR_F_MASK    = 8'h80;
    localparam logic [7:0] HDR_IDC_MASK  = 8'h60;
    localparam logic [7:0] HDR_TYPE_MASK = 8'h1f;

    localparam logic [2:0] PREFIX_SHORT = 3'd3;
    localparam logic [2:0] PREFIX_LONG  = 3'd4;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  payload_byte;
        logic        hdr_zero_bit;
        logic [1:0]  ref_idc;
        logic [4:0]  unit_type;
        logic [19:0] nal_length;
        logic [2:0]  prefix_length;
        logic        truncated;
        logic        last;
    } t_out_word;

    typedef t_out_word [MAX_RES-1:0] t_bundle;

    // window scan of one byte: bytes leaving toward the open unit and start code info
    typedef struct packed {
        logic [SEG_N-1:0][7:0] seg_byte;
        logic [2:0]            seg_n;
        logic                  found;
        logic [2:0]            found_prefix;
        logic                  eos;
    } t_scan;

    function automatic t_out_word f_payload(input logic [7:0] b);
        t_out_word w;
        w              = '0;
        w.result_kind  = KIND_PAYLOAD;
        w.payload_byte = b;
        return w;
    endfunction

    function automatic t_out_word f_summary(input logic [7:0] h, input logic [19:0] len,
                                            input logic [2:0] pre, input logic tr);
        t_out_word w;
        w               = '0;
        w.result_kind   = KIND_SUMMARY;
        w.hdr_zero_bit  = (h & HDR_F_MASK) != ZERO_BYTE;
        w.ref_idc       = 2'((h & HDR_IDC_MASK) >> 5);
        w.unit_type     = 5'(h & HDR_TYPE_MASK);
        w.nal_length    = len;
        w.prefix_length = pre;
        w.truncated     = tr;
        return w;
    endfunction

endpackage

// ===== rtl/core/nalsp_window.sv =====
// four byte hold window and start code detector
// depends on nalsp_pkg
module nalsp_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output nalsp_pkg::t_scan  o_scan
);

    logic [nalsp_pkg::WIN_DEPTH-1:0][7:0] r_win, n_win;
    logic [2:0]                           r_held, n_held;

    logic [nalsp_pkg::WIN_DEPTH-1:0][7:0] w_next;
    logic [2:0]                           w_held;
    logic                                 w_shift;
    logic                                 w_f4, w_f3, w_pre1;
    logic [2:0]                           w_rest;

    always_comb begin
        w_shift = (r_held == 3'd4);
        if (w_shift) begin
            w_next[0] = r_win[1];
            w_next[1] = r_win[2];
            w_next[2] = r_win[3];
            w_next[3] = i_byte;
            w_held    = 3'd4;
        end else begin
            w_next              = r_win;
            w_next[r_held[1:0]] = i_byte;
            w_held              = r_held + 3'd1;
        end

        w_f4 = (w_held == 3'd4) && (w_next[0] == nalsp_pkg::ZERO_BYTE)
             && (w_next[1] == nalsp_pkg::ZERO_BYTE) && (w_next[2] == nalsp_pkg::ZERO_BYTE)
             && (w_next[3] == nalsp_pkg::CODE_BYTE);
        w_f3 = ((w_held == 3'd4) && (w_next[1] == nalsp_pkg::ZERO_BYTE)
                && (w_next[2] == nalsp_pkg::ZERO_BYTE) && (w_next[3] == nalsp_pkg::CODE_BYTE))
            || ((w_held == 3'd3) && (w_next[0] == nalsp_pkg::ZERO_BYTE)
                && (w_next[1] == nalsp_pkg::ZERO_BYTE) && (w_next[2] == nalsp_pkg::CODE_BYTE));
        // short code at the back of a full window leaves one byte in front of it
        w_pre1 = !w_f4 && w_f3 && (w_held == 3'd4);

        if (w_pre1) begin
            w_rest = 3'd1;
        end else if (i_eos && !(w_f4 || w_f3)) begin
            w_rest = w_held;
        end else begin
            w_rest = 3'd0;
        end

        o_scan.seg_byte[0] = w_shift ? r_win[0] : w_next[0];
        for (int j = 1; j < nalsp_pkg::WIN_DEPTH; j++) begin
            o_scan.seg_byte[j] = w_shift ? w_next[j-1] : w_next[j];
        end
        o_scan.seg_byte[4]  = w_shift ? w_next[3] : nalsp_pkg::ZERO_BYTE;
        o_scan.seg_n        = 3'(w_shift) + w_rest;
        o_scan.found        = w_f4 || w_f3;
        o_scan.found_prefix = w_f4 ? nalsp_pkg::PREFIX_LONG : nalsp_pkg::PREFIX_SHORT;
        o_scan.eos          = i_eos;

        n_win  = r_win;
        n_held = r_held;
        if (i_adv) begin
            if (i_eos) begin
                n_win  = '0;
                n_held = 3'd0;
            end else if (o_scan.found) begin
                n_win  = w_next;
                n_held = 3'd0;
            end else begin
                n_win  = w_next;
                n_held = w_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_held <= 3'd0;
        end else begin
            r_win  <= n_win;
            r_held <= n_held;
        end
    end

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 3'd4)
        else $error("window holds more than four bytes");

    a_found_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (o_scan.found || i_eos)) |=> (r_held == 3'd0))
        else $error("window not emptied after start code or end of stream");

endmodule

// ===== rtl/core/nalsp_track.sv =====
// nal unit tracker: header, length, truncation and the result list of one byte
// depends on nalsp_pkg
module nalsp_track #(
    parameter int LENGTH_BITS = nalsp_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  nalsp_pkg::t_scan            i_scan,
    input  logic [nalsp_pkg::CFG_W-1:0] i_max,
    output nalsp_pkg::t_bundle          o_bun,
    output logic [2:0]                  o_cnt
);

    localparam int WW = (LENGTH_BITS > nalsp_pkg::CFG_W) ? LENGTH_BITS : nalsp_pkg::CFG_W;

    logic                   r_inside, n_inside;
    logic [2:0]             r_prefix, n_prefix;
    logic [7:0]             r_hdr, n_hdr;
    logic                   r_hseen, n_hseen;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_ovf, n_ovf;

    logic [WW-1:0]                          w_cfg, w_cap, w_lim_w;
    logic [LENGTH_BITS-1:0]                 w_limit;
    logic [LENGTH_BITS:0]                   w_room;
    logic [nalsp_pkg::SEG_N-1:0]            w_acc;
    logic [2:0]                             w_k;
    logic [7:0]                             w_hdr_a;
    logic                                   w_hseen_a, w_ovf_a;
    logic [LENGTH_BITS-1:0]                 w_len_a;
    logic                                   w_sum_a, w_sum_b;
    nalsp_pkg::t_out_word                   w_word_a, w_word_b, w_first;
    logic [nalsp_pkg::MAX_RES-1:0][7:0]     w_pad;

    always_comb begin
        // limit capped to the counter width
        w_cfg   = WW'(i_max);
        w_cap   = WW'({LENGTH_BITS{1'b1}});
        w_lim_w = (w_cfg > w_cap) ? w_cap : w_cfg;
        w_limit = w_lim_w[LENGTH_BITS-1:0];
        w_room  = {1'b0, w_limit} - {1'b0, r_len};

        w_k = 3'd0;
        for (int j = 0; j < nalsp_pkg::SEG_N; j++) begin
            w_acc[j] = r_inside && (3'(j) < i_scan.seg_n) && !w_room[LENGTH_BITS]
                     && (w_room[LENGTH_BITS-1:0] > LENGTH_BITS'(j));
            w_k      = w_k + 3'(w_acc[j]);
        end

        w_hseen_a = r_hseen;
        w_hdr_a   = r_hdr;
        if (r_inside && !r_hseen && (i_scan.seg_n != 3'd0)) begin
            w_hseen_a = 1'b1;
            w_hdr_a   = i_scan.seg_byte[0];
        end
        w_ovf_a = r_ovf || (r_inside && (i_scan.seg_n > w_k));
        w_len_a = r_len + LENGTH_BITS'(w_k);

        w_sum_a  = r_inside && (i_scan.found || i_scan.eos);
        w_sum_b  = i_scan.found && i_scan.eos;
        w_word_a = nalsp_pkg::f_summary(w_hseen_a ? w_hdr_a : nalsp_pkg::ZERO_BYTE,
                                        20'(w_len_a), r_prefix, w_ovf_a);
        // unit opened and closed by the same byte
        w_word_b = nalsp_pkg::f_summary(nalsp_pkg::ZERO_BYTE, 20'd0,
                                        i_scan.found_prefix, 1'b0);
        w_first  = w_sum_a ? w_word_a : w_word_b;

        w_pad                          = '0;
        w_pad[nalsp_pkg::SEG_N-1:0]    = i_scan.seg_byte;
        o_cnt = w_k + 3'(w_sum_a) + 3'(w_sum_b);
        for (int j = 0; j < nalsp_pkg::MAX_RES; j++) begin
            if (3'(j) < w_k) begin
                o_bun[j] = nalsp_pkg::f_payload(w_pad[j]);
            end else if (3'(j) == w_k) begin
                o_bun[j] = w_first;
            end else begin
                o_bun[j] = w_word_b;
            end
            o_bun[j].last = (o_cnt != 3'd0) && (3'(j) == o_cnt - 3'd1);
        end

        n_inside = r_inside;
        n_prefix = r_prefix;
        n_hdr    = r_hdr;
        n_hseen  = r_hseen;
        n_len    = r_len;
        n_ovf    = r_ovf;
        if (i_adv) begin
            if (i_scan.eos) begin
                n_inside = 1'b0;
                n_prefix = nalsp_pkg::PREFIX_SHORT;
                n_hdr    = nalsp_pkg::ZERO_BYTE;
                n_hseen  = 1'b0;
                n_len    = '0;
                n_ovf    = 1'b0;
            end else if (i_scan.found) begin
                n_inside = 1'b1;
                n_prefix = i_scan.found_prefix;
                n_hdr    = nalsp_pkg::ZERO_BYTE;
                n_hseen  = 1'b0;
                n_len    = '0;
                n_ovf    = 1'b0;
            end else begin
                n_hdr    = w_hdr_a;
                n_hseen  = w_hseen_a;
                n_len    = w_len_a;
                n_ovf    = w_ovf_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_prefix <= nalsp_pkg::PREFIX_SHORT;
            r_hdr    <= nalsp_pkg::ZERO_BYTE;
            r_hseen  <= 1'b0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_inside <= n_inside;
            r_prefix <= n_prefix;
            r_hdr    <= n_hdr;
            r_hseen  <= n_hseen;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_len == '0) && !r_hseen && !r_ovf)
        else $error("unit state left over outside a unit");

    a_eos_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_scan.eos) |=> !r_inside)
        else $error("unit still open after end of stream");

endmodule

// ===== rtl/core/nalsp_result.sv =====
// result list register, drained one word per cycle while the output is not stalled
// depends on nalsp_pkg
module nalsp_result (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  nalsp_pkg::t_bundle    i_bun,
    input  logic [2:0]            i_cnt,
    input  logic                  i_out_stall,
    output logic                  o_valid,
    output nalsp_pkg::t_out_word  o_word,
    output logic                  o_free
);

    nalsp_pkg::t_bundle r_bun, n_bun;
    logic [2:0]         r_cnt, n_cnt;
    logic [2:0]         r_idx, n_idx;

    logic w_take, w_final;

    always_comb begin
        o_valid = (r_cnt != 3'd0);
        o_word  = r_bun[r_idx];
        w_take  = o_valid && !i_out_stall;
        w_final = w_take && (r_idx == r_cnt - 3'd1);
        o_free  = !o_valid || w_final;

        n_bun = r_bun;
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_bun = i_bun;
            n_cnt = i_cnt;
            n_idx = 3'd0;
        end else if (w_final) begin
            n_cnt = 3'd0;
            n_idx = 3'd0;
        end else if (w_take) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bun <= n_bun;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 3'd0) |-> (r_idx < r_cnt) && (r_cnt <= 3'(nalsp_pkg::MAX_RES)))
        else $error("result index beyond list");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cnt != 3'd0) && (r_idx == r_cnt - 3'd1)) |-> o_word.last)
        else $error("final word of a list not marked last");

endmodule

// ===== rtl/core/annexb_nal_unit_splitter_top.sv =====
// top level of the annex b nal unit splitter: input register, config register, wiring
// depends on nalsp_pkg, nalsp_window, nalsp_track, nalsp_result
//
// channel   direction  handshake              word
// --------  ---------  ---------------------  -----------------------------------------
// in        sink       i_in_valid/o_in_stall  t_in_word: stream byte, end of stream
// out       source     o_out_valid/i_out_stall t_out_word: payload byte or unit summary
// config    apb slave  psel/penable/pready    max_nal_length at byte address 0
//
// one stream byte per clock while the result list is free; a byte with n results gives n
// output words (up to six on end of stream); the result list register paces the input
// reset is synchronous and active low; it empties the window and closes any open unit
// o_in_stall rises only while the input register holds a byte and the result list cannot
// take the next one, so a stalled output lets one more byte in before the input stalls
module annexb_nal_unit_splitter_top #(
    parameter int LENGTH_BITS = nalsp_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nalsp_pkg::t_in_word           i_in_word,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nalsp_pkg::t_out_word          o_out_word,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nalsp_pkg::PADDR_W-1:0] paddr,
    input  logic [nalsp_pkg::PDATA_W-1:0] pwdata,
    output logic [nalsp_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    // input register
    logic                  r_in_valid, n_in_valid;
    nalsp_pkg::t_in_word   r_in_word, n_in_word;

    // max_nal_length register
    logic [nalsp_pkg::CFG_W-1:0] r_max, n_max;

    logic                  w_free;
    logic                  w_adv;
    logic                  w_in_take;
    logic                  w_sel_max;
    nalsp_pkg::t_scan      w_scan;
    nalsp_pkg::t_bundle    w_bun;
    logic [2:0]            w_cnt;

    always_comb begin
        // the held word moves on once the result list can take its results
        w_adv      = r_in_valid && w_free;
        o_in_stall = r_in_valid && !w_free;
        w_in_take  = i_in_valid && !o_in_stall;

        n_in_valid = r_in_valid;
        n_in_word  = r_in_word;
        if (w_in_take) begin
            n_in_valid = 1'b1;
            n_in_word  = i_in_word;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end

        // single register, so the index is the address bit above the byte lanes
        pready    = 1'b1;
        w_sel_max = (paddr[2] == nalsp_pkg::REG_MAX_NAL_LENGTH);
        n_max     = r_max;
        if (psel && penable && pwrite && w_sel_max) begin
            n_max = pwdata[nalsp_pkg::CFG_W-1:0];
        end
        prdata = w_sel_max ? nalsp_pkg::PDATA_W'(r_max) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max      <= nalsp_pkg::MAX_NAL_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            r_max      <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_word <= n_in_word;
    end

    // window and start code detection
    nalsp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_word.stream_byte),
        .i_eos   (r_in_word.end_of_stream),
        .o_scan  (w_scan)
    );

    // unit bookkeeping and result list
    nalsp_track #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_scan  (w_scan),
        .i_max   (r_max),
        .o_bun   (w_bun),
        .o_cnt   (w_cnt)
    );

    // result list register and output side
    nalsp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_adv && (w_cnt != 3'd0)),
        .i_bun       (w_bun),
        .i_cnt       (w_cnt),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_word      (o_out_word),
        .o_free      (w_free)
    );

endmodule
